[rtl/masked_bit_gather_packer_macros.svh]
// ----------------------------------------------------------------------------
// masked_bit_gather_packer_macros.svh
// assertion helpers shared by the packer rtl
// ----------------------------------------------------------------------------
`ifndef MASKED_BIT_GATHER_PACKER_MACROS_SVH
`define MASKED_BIT_GATHER_PACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBGP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packer check failed: same cycle");

// next-cycle implication, checked out of reset
`define MBGP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packer check failed: next cycle");

`endif

[rtl/mbgp_pkg.sv]
// ----------------------------------------------------------------------------
// mbgp_pkg
// shared widths and word types for the masked bit gather packer
// ----------------------------------------------------------------------------
package mbgp_pkg;

    localparam int FIELD_BITS    = 64;
    localparam int VALID_BITS    = 7;
    localparam int WORD_BITS_DEF = 64;

    typedef struct packed {
        logic [FIELD_BITS-1:0] mask_word;
        logic [FIELD_BITS-1:0] data_word;
        logic                  last_in;
    } mbgp_in_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] packed_word;
        logic [VALID_BITS-1:0] bits_valid;
        logic                  last_out;
    } mbgp_out_t;

endpackage

[rtl/mbgp_extract.sv]
// ----------------------------------------------------------------------------
// mbgp_extract
// parallel bit extract: data bits at set mask positions, packed lsb first
// ----------------------------------------------------------------------------
module mbgp_extract #(
    parameter int WORD_BITS = 64,
    parameter int CW        = 7
) (
    input  logic [WORD_BITS-1:0] mask,
    input  logic [WORD_BITS-1:0] data,
    output logic [WORD_BITS-1:0] gathered,
    output logic [CW-1:0]        count
);

    logic [CW-1:0] rank [WORD_BITS];

    // rank of each position = set mask bits below it
    always_comb
    begin
        for (int pos = 0; pos < WORD_BITS; pos++)
        begin
            rank[pos] = CW'($countones(mask & ((WORD_BITS'(1) << pos) - WORD_BITS'(1))));
        end
    end

    always_comb
    begin
        for (int g = 0; g < WORD_BITS; g++)
        begin
            gathered[g] = 1'b0;
            for (int pos = 0; pos < WORD_BITS; pos++)
            begin
                gathered[g] = gathered[g] |
                              (mask[pos] & data[pos] & (rank[pos] == CW'(g)));
            end
        end
    end

    assign count = CW'($countones(mask));

endmodule

[rtl/masked_bit_gather_packer.sv]
// ----------------------------------------------------------------------------
// masked_bit_gather_packer
// gathers the data bits selected by a mask and packs them into full words
//
// vec channel: one mask/data word per handshake, last_in closes the vector.
// pack channel: packed words lsb first with bits_valid; every full word goes
// out at once, the leftover of a vector goes out zero padded with last_out,
// and a last word with no bits left to send yields a zero-length word with last_out.
// an accepted word passes through the input register, then the output
// register, and is on pack from then on. throughput: one word per cycle
// while pack is not stalled; a word that yields two results (a full word
// plus the tail on last_in) holds the input register until its tail loads.
// the output register frees the input side whenever pack is not stalled, so a
// stalled receiver backs up into vec_stall only once both registers are full.
// reset clears both valid flags and the pending bits; the next word accepted
// starts a new vector. after a word with last_in the same holds.
// ----------------------------------------------------------------------------
`include "masked_bit_gather_packer_macros.svh"

module masked_bit_gather_packer #(
    parameter int WORD_BITS = mbgp_pkg::WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vec_valid,
    output logic              vec_stall,
    input  mbgp_pkg::mbgp_in_t  vec_data,
    output logic              pack_valid,
    input  logic              pack_stall,
    output mbgp_pkg::mbgp_out_t pack_data
);

    import mbgp_pkg::*;

    localparam int FW = $clog2(WORD_BITS);
    localparam int CW = FW + 1;
    localparam int WW = 2 * WORD_BITS;

    mbgp_in_t               in_reg;
    logic                   in_valid_reg;
    logic                   second_reg;
    mbgp_out_t              out_reg;
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   pending_reg;
    logic [FW-1:0]          fill_reg;

    logic [WORD_BITS-1:0]   gathered;
    logic [CW-1:0]          count;
    logic [WW-1:0]          wide;
    logic [CW-1:0]          sum;
    logic                   full;
    logic [FW-1:0]          rest;
    logic                   two_res;
    logic                   has_result;
    logic                   step;
    logic                   consume;
    logic                   load;
    mbgp_out_t              res_first;
    mbgp_out_t              res_second;
    logic [WORD_BITS-1:0]   pending_next;
    logic [FW-1:0]          fill_next;

    mbgp_extract #(
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_extract (
        .mask     (in_reg.mask_word[WORD_BITS-1:0]),
        .data     (in_reg.data_word[WORD_BITS-1:0]),
        .gathered (gathered),
        .count    (count)
    );

    always_comb
    begin
        wide       = WW'(pending_reg) | (WW'(gathered) << fill_reg);
        sum        = CW'(fill_reg) + count;
        full       = (sum >= CW'(WORD_BITS));
        rest       = FW'(sum - CW'(WORD_BITS));
        two_res    = full && in_reg.last_in && (rest != '0);
        has_result = full || in_reg.last_in;

        res_first.packed_word = FIELD_BITS'(wide[WORD_BITS-1:0]);
        if (full)
        begin
            res_first.bits_valid = VALID_BITS'(WORD_BITS);
            res_first.last_out   = in_reg.last_in && (rest == '0);
        end
        else
        begin
            res_first.bits_valid = VALID_BITS'(sum);
            res_first.last_out   = 1'b1;
        end

        // tail of the vector left after a full word
        res_second.packed_word = FIELD_BITS'(wide[WW-1:WORD_BITS]);
        res_second.bits_valid  = VALID_BITS'(rest);
        res_second.last_out    = 1'b1;

        step    = in_valid_reg && (!has_result || !out_valid_reg || !pack_stall);
        consume = step && !(two_res && !second_reg);
        load    = step && has_result;

        if (in_reg.last_in)
        begin
            pending_next = '0;
            fill_next    = '0;
        end
        else if (full)
        begin
            pending_next = wide[WW-1:WORD_BITS];
            fill_next    = rest;
        end
        else
        begin
            pending_next = wide[WORD_BITS-1:0];
            fill_next    = FW'(sum);
        end
    end

    assign vec_stall  = in_valid_reg && !consume;
    assign pack_valid = out_valid_reg;
    assign pack_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (!vec_stall)
            begin
                in_valid_reg <= vec_valid;
            end
            if (consume)
            begin
                second_reg  <= 1'b0;
                pending_reg <= pending_next;
                fill_reg    <= fill_next;
            end
            else if (step)
            begin
                second_reg <= 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!pack_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vec_valid && !vec_stall)
        begin
            in_reg <= vec_data;
        end
        if (load)
        begin
            out_reg <= second_reg ? res_second : res_first;
        end
    end

    `MBGP_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= FW'(WORD_BITS - 1))
    `MBGP_ASSERT_NOW(a_pending_clean, 1'b1, (pending_reg >> fill_reg) == '0)
    `MBGP_ASSERT_NEXT(a_last_clears, consume && in_reg.last_in, fill_reg == '0 && pending_reg == '0)
    `MBGP_ASSERT_NOW(a_second_full, second_reg, out_valid_reg && out_reg.bits_valid == VALID_BITS'(WORD_BITS))

endmodule

[verif/masked_bit_gather_packer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_bit_gather_packer_test
// self-checking bench for the masked bit gather packer
//
// a short table of directed words runs first, then random vectors of random
// length and mask density. a scoreboard model gathers the masked data bits
// and packs them to predict every pack word the table does not type. both
// channels idle at random, the receiver holds off once for a long stretch,
// and the sender once drains the block before it goes on.
// ----------------------------------------------------------------------------
module masked_bit_gather_packer_test;
    import mbgp_pkg::*;

    localparam logic [FIELD_BITS-1:0] ALL_ONES   = '1;
    localparam logic [VALID_BITS-1:0] FULL_COUNT = VALID_BITS'(FIELD_BITS);
    localparam int NUM_RANDOM  = 750;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AFTER  = 200;
    localparam int DRAIN_AFTER = 450;
    localparam int NOT_TYPED   = -1;

    typedef struct {
        mbgp_in_t  word;
        int        n_typed;
        mbgp_out_t res0;
        mbgp_out_t res1;
    } dir_row_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      vec_valid  = 1'b0;
    logic      vec_stall;
    mbgp_in_t  vec_data   = '0;
    logic      pack_valid;
    logic      pack_stall = 1'b0;
    mbgp_out_t pack_data;

    // expectation typed into the table for the word on the bus
    int        row_n_typed = NOT_TYPED;
    mbgp_out_t row_res0    = '0;
    mbgp_out_t row_res1    = '0;

    logic [FIELD_BITS-1:0] pend_bits  = '0;
    int                    pend_count = 0;
    mbgp_out_t             step_q[$];
    mbgp_out_t             packed_due_q[$];
    mbgp_out_t             due;
    int                    results_seen = 0;
    int                    mismatches   = 0;
    int                    words_sent   = 0;

    masked_bit_gather_packer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_stall  (vec_stall),
        .vec_data   (vec_data),
        .pack_valid (pack_valid),
        .pack_stall (pack_stall),
        .pack_data  (pack_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // gathers the masked bits of one word onto the pending bits and leaves
    // the pack words it completes in step_q
    task automatic gather_and_pack(input mbgp_in_t w);
        logic [FIELD_BITS-1:0]   kept;
        logic [2*FIELD_BITS-1:0] acc;
        mbgp_out_t               r;
        int                      n_kept;
        int                      total;
        int                      p;
        kept   = '0;
        n_kept = 0;
        step_q.delete();
        for (p = 0; p < FIELD_BITS; p++)
        begin
            if (w.mask_word[p])
            begin
                kept[n_kept] = w.data_word[p];
                n_kept++;
            end
        end
        acc   = {{FIELD_BITS{1'b0}}, pend_bits} | ({{FIELD_BITS{1'b0}}, kept} << pend_count);
        total = pend_count + n_kept;
        if (total >= FIELD_BITS)
        begin
            r.packed_word = acc[FIELD_BITS-1:0];
            r.bits_valid  = FULL_COUNT;
            r.last_out    = w.last_in && (total == FIELD_BITS);
            step_q.push_back(r);
            acc   = acc >> FIELD_BITS;
            total = total - FIELD_BITS;
        end
        if (w.last_in)
        begin
            // tail of the vector, or a zero-length word when nothing went out
            if (total > 0 || step_q.size() == 0)
            begin
                r.packed_word = acc[FIELD_BITS-1:0];
                r.bits_valid  = VALID_BITS'(total);
                r.last_out    = 1'b1;
                step_q.push_back(r);
            end
            pend_bits  = '0;
            pend_count = 0;
        end
        else
        begin
            pend_bits  = acc[FIELD_BITS-1:0];
            pend_count = total;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && vec_valid && !vec_stall)
        begin
            gather_and_pack(vec_data);
            if (row_n_typed == NOT_TYPED)
            begin
                foreach (step_q[k])
                    packed_due_q.push_back(step_q[k]);
            end
            else
            begin
                if (row_n_typed > 0)
                    packed_due_q.push_back(row_res0);
                if (row_n_typed > 1)
                    packed_due_q.push_back(row_res1);
            end
        end
        if (rst_n && pack_valid && !pack_stall)
        begin
            results_seen++;
            if (packed_due_q.size() == 0)
            begin
                $error("unexpected pack word %h", pack_data.packed_word);
                mismatches++;
            end
            else
            begin
                due = packed_due_q.pop_front();
                if (pack_data.packed_word !== due.packed_word)
                begin
                    $error("packed_word: expected %h, got %h",
                           due.packed_word, pack_data.packed_word);
                    mismatches++;
                end
                if (pack_data.bits_valid !== due.bits_valid)
                begin
                    $error("bits_valid: expected %0d, got %0d",
                           due.bits_valid, pack_data.bits_valid);
                    mismatches++;
                end
                if (pack_data.last_out !== due.last_out)
                begin
                    $error("last_out: expected %0b, got %0b", due.last_out, pack_data.last_out);
                    mismatches++;
                end
            end
        end
    end

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_mask();
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] c;
        int                    lo;
        int                    hi;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return ALL_ONES;
            1: return '0;
            2: return a & b & c;
            3: return a | b;
            4: return {{FIELD_BITS-1{1'b0}}, 1'b1} << $urandom_range(0, FIELD_BITS-1);
            5:
            begin
                lo = $urandom_range(0, FIELD_BITS-1);
                hi = $urandom_range(lo, FIELD_BITS-1);
                return (ALL_ONES >> (FIELD_BITS-1-hi)) & (ALL_ONES << lo);
            end
            default: return a;
        endcase
    endfunction

    function automatic dir_row_t make_row(input logic [FIELD_BITS-1:0] m,
                                          input logic [FIELD_BITS-1:0] d,
                                          input logic l, input int n,
                                          input mbgp_out_t r0 = '0,
                                          input mbgp_out_t r1 = '0);
        dir_row_t row;
        row.word.mask_word = m;
        row.word.data_word = d;
        row.word.last_in   = l;
        row.n_typed        = n;
        row.res0           = r0;
        row.res1           = r1;
        return row;
    endfunction

    // the word stays on the bus until the edge that accepts it
    task automatic put_word(input mbgp_in_t w, input int gap, input int n_typed,
                            input mbgp_out_t r0, input mbgp_out_t r1);
        if (gap > 0)
        begin
            vec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_valid   <= 1'b1;
        vec_data    <= w;
        row_n_typed <= n_typed;
        row_res0    <= r0;
        row_res1    <= r1;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // receiver: runs of ready cycles and stalls, one long hold-off
    initial
    begin
        int stall_left;
        int run_left;
        bit long_done;
        stall_left = 0;
        run_left   = 0;
        long_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_done && results_seen >= HOLD_AFTER)
            begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && run_left == 0)
            begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 12);
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                         : $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                pack_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                pack_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    // sender
    initial
    begin
        dir_row_t rows[$];
        mbgp_in_t w;
        int       n_rand;
        int       len;
        bit       burst;
        bit       drained;
        n_rand  = 0;
        drained = 1'b0;

        // zero-length word, full words, a word split over two results
        rows.push_back(make_row('0, ALL_ONES, 1'b1, 1,
                                mbgp_out_t'{'0, '0, 1'b1}));
        rows.push_back(make_row(ALL_ONES, ALL_ONES, 1'b1, 1,
                                mbgp_out_t'{ALL_ONES, FULL_COUNT, 1'b1}));
        rows.push_back(make_row(ALL_ONES, 64'h0123_4567_89AB_CDEF, 1'b0, 1,
                                mbgp_out_t'{64'h0123_4567_89AB_CDEF, FULL_COUNT, 1'b0}));
        rows.push_back(make_row(ALL_ONES, '0, 1'b1, 1,
                                mbgp_out_t'{'0, FULL_COUNT, 1'b1}));
        rows.push_back(make_row(64'h1, 64'h1, 1'b1, 1,
                                mbgp_out_t'{64'h1, 7'd1, 1'b1}));
        rows.push_back(make_row(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 0));
        rows.push_back(make_row('0, ALL_ONES, 1'b1, 1,
                                mbgp_out_t'{64'h1, 7'd1, 1'b1}));
        rows.push_back(make_row(64'h1, 64'h1, 1'b0, 0));
        rows.push_back(make_row(ALL_ONES, ALL_ONES, 1'b1, 2,
                                mbgp_out_t'{ALL_ONES, FULL_COUNT, 1'b0},
                                mbgp_out_t'{64'h1, 7'd1, 1'b1}));
        rows.push_back(make_row(64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES, 1'b0, 0));
        rows.push_back(make_row(64'h5555_5555_5555_5555, '0, 1'b0, 1,
                                mbgp_out_t'{64'h0000_0000_FFFF_FFFF, FULL_COUNT, 1'b0}));
        rows.push_back(make_row('0, '0, 1'b1, 1,
                                mbgp_out_t'{'0, '0, 1'b1}));
        rows.push_back(make_row(64'hF0F0_F0F0_F0F0_F0F0, 64'h1234_5678_9ABC_DEF0, 1'b0,
                                NOT_TYPED));
        rows.push_back(make_row(64'h0000_0000_FFFF_FFFF, 64'hC3A5_5A3C_0F1E_2D4B, 1'b0,
                                NOT_TYPED));
        rows.push_back(make_row(64'hFFFF_0000_FFFF_0000, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0,
                                NOT_TYPED));
        rows.push_back(make_row(64'h8000_0000_0000_0001, ALL_ONES, 1'b0, NOT_TYPED));
        rows.push_back(make_row(64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555, 1'b1,
                                NOT_TYPED));
        rows.push_back(make_row(64'h1, '0, 1'b0, NOT_TYPED));
        rows.push_back(make_row(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NOT_TYPED));
        rows.push_back(make_row(64'h3, 64'h3, 1'b1, NOT_TYPED));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            put_word(rows[i].word, pick_gap(1'b0), rows[i].n_typed,
                     rows[i].res0, rows[i].res1);

        // random vectors, some sent back to back
        while (n_rand < NUM_RANDOM)
        begin
            len   = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
            burst = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++)
            begin
                w.mask_word = rand_mask();
                w.data_word = {$urandom, $urandom};
                w.last_in   = (j == len - 1);
                put_word(w, pick_gap(burst), NOT_TYPED, '0, '0);
                n_rand++;
            end
            if (!drained && words_sent >= DRAIN_AFTER)
            begin
                drained = 1'b1;
                vec_valid <= 1'b0;
                @(posedge clk);
                while (packed_due_q.size() != 0)
                    @(posedge clk);
            end
        end

        vec_valid <= 1'b0;
        @(posedge clk);
        while (packed_due_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && packed_due_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/mbgp_pkg.sv
rtl/mbgp_extract.sv
rtl/masked_bit_gather_packer.sv
verif/masked_bit_gather_packer_test.sv
